// ===== design/sha_pkg.sv =====
// Package for the SHA-256 hash core: constants, round table, front-to-back command type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
  localparam int LengthFieldBits = 64;
  localparam int QueueDepth = 4;
  localparam int QueueAw = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       is_empty;
  } sha_cmd_t;

  typedef logic [7:0][31:0] sha_hash_t;

  localparam sha_hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

// ===== design/sha_cmd_queue.sv =====
// Short queue of byte transactions between the front and the back of the hash core.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_cmd_queue import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  output logic          wr_stall,
  input  wire sha_cmd_t wr_cmd,
  output logic          rd_valid,
  input  wire logic     rd_take,
  output sha_cmd_t      rd_cmd
);
  sha_cmd_t              slot_r [QueueDepth];
  logic [QueueAw-1:0]    wptr_r, rptr_r;
  logic [QueueAw:0]      count_r;
  logic                  push, pop;

  assign wr_stall = (count_r == (QueueAw+1)'(QueueDepth));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = slot_r[rptr_r];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
    if (push) slot_r[wptr_r] <= wr_cmd;
  end
endmodule
`default_nettype wire

// ===== design/sha_engine.sv =====
// Back end of the hash core: block packing, padding, 64-round compression, digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_engine import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  output logic          cmd_take,
  input  wire sha_cmd_t cmd,
  output logic          out_valid,
  input  wire logic     out_stall,
  output logic [31:0]   out_digest_word,
  output logic [2:0]    out_word_index,
  output logic          out_last_word
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StInit = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  sha_hash_t        hash_r, hash_nxt;
  logic [7:0][31:0] wv_r, wv_nxt;
  logic [31:0]      ring_r [16];
  logic [31:0]      w_r, w_nxt;
  logic [60:0]      total_r, total_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [6:0]       round_r, round_nxt;
  logic             padding_r, padding_nxt;
  logic             wrap_r, wrap_nxt;
  logic             final_r, final_nxt;
  logic             last_pend_r, last_pend_nxt;
  logic [63:0]      bitlen_r, bitlen_nxt;
  logic [2:0]       oidx_r, oidx_nxt;

  logic [7:0]  pad_byte;
  logic [7:0]  put_val;
  logic        put_en;
  logic [31:0] put_word;
  logic [5:0]  t6, tn6;
  logic [31:0] xm1, xm6, xm14, xm15, sched_w, s0, s1, ws0, ws1, ch, maj, t1, t2;
  logic [60:0] total_inc;
  logic [63:0] len_mask;

  assign len_mask = {64{1'b1}} >> (64 - LengthFieldBits);
  assign t6 = round_r[5:0];
  assign tn6 = t6 + 6'd1;
  assign total_inc = total_r + 61'd1;

  always_comb begin
    if (!padding_r) pad_byte = 8'h80;
    else if (fill_r < 6'd56 || wrap_r) pad_byte = 8'h00;
    else pad_byte = 8'(bitlen_r >> {3'd7 - fill_r[2:0], 3'b000});
  end

  assign cmd_take = (state_r == StIdle) && cmd_valid;
  assign put_en = ((state_r == StIdle) && cmd_valid && !cmd.is_empty) || (state_r == StPad);
  assign put_val = (state_r == StPad) ? pad_byte : cmd.data;

  always_comb begin
    put_word = (fill_r[1:0] == 2'd0) ? 32'd0 : ring_r[fill_r[5:2]];
    unique case (fill_r[1:0])
      2'd0: put_word[31:24] = put_val;
      2'd1: put_word[23:16] = put_val;
      2'd2: put_word[15:8]  = put_val;
      2'd3: put_word[7:0]   = put_val;
    endcase
  end

  assign xm1  = ring_r[4'(t6 - 6'd1)];
  assign xm6  = ring_r[4'(t6 - 6'd6)];
  assign xm14 = ring_r[4'(t6 - 6'd14)];
  assign xm15 = ring_r[tn6[3:0]];
  assign ws1 = {xm1[16:0], xm1[31:17]} ^ {xm1[18:0], xm1[31:19]} ^ (xm1 >> 10);
  assign ws0 = {xm14[6:0], xm14[31:7]} ^ {xm14[17:0], xm14[31:18]} ^ (xm14 >> 3);
  assign sched_w = (round_r < 7'd15) ? xm15 : ws1 + xm6 + ws0 + xm15;
  assign s1  = {wv_r[4][5:0], wv_r[4][31:6]} ^ {wv_r[4][10:0], wv_r[4][31:11]}
             ^ {wv_r[4][24:0], wv_r[4][31:25]};
  assign ch  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign s0  = {wv_r[0][1:0], wv_r[0][31:2]} ^ {wv_r[0][12:0], wv_r[0][31:13]}
             ^ {wv_r[0][21:0], wv_r[0][31:22]};
  assign maj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1  = wv_r[7] + s1 + ch + round_k(t6) + w_r;
  assign t2  = s0 + maj;

  always_comb begin
    state_nxt = state_r;
    hash_nxt = hash_r;
    wv_nxt = wv_r;
    w_nxt = w_r;
    total_nxt = total_r;
    fill_nxt = put_en ? fill_r + 6'd1 : fill_r;
    round_nxt = round_r;
    padding_nxt = padding_r;
    wrap_nxt = wrap_r;
    final_nxt = final_r;
    last_pend_nxt = last_pend_r;
    bitlen_nxt = bitlen_r;
    oidx_nxt = oidx_r;
    unique case (state_r)
      StIdle: if (cmd_valid) begin
        if (!cmd.is_empty) total_nxt = total_inc;
        if (cmd.is_last) begin
          bitlen_nxt = {cmd.is_empty ? total_r : total_inc, 3'b000} & len_mask;
          last_pend_nxt = 1'b1;
        end
        if (!cmd.is_empty && fill_r == 6'd63) state_nxt = StInit;
        else if (cmd.is_last) state_nxt = StPad;
      end
      StPad: begin
        padding_nxt = 1'b1;
        if (!padding_r) wrap_nxt = (fill_r >= 6'd56) && (fill_r != 6'd63);
        else if (fill_r == 6'd63) wrap_nxt = 1'b0;
        if (fill_r == 6'd63) begin
          final_nxt = padding_r && !wrap_r;
          state_nxt = StInit;
        end
      end
      StInit: begin
        wv_nxt = hash_r;
        w_nxt = ring_r[0];
        round_nxt = '0;
        state_nxt = StRnd;
      end
      StRnd: begin
        wv_nxt = {wv_r[6], wv_r[5], wv_r[4], wv_r[3] + t1,
                  wv_r[2], wv_r[1], wv_r[0], t1 + t2};
        w_nxt = sched_w;
        round_nxt = round_r + 7'd1;
        if (round_r == 7'd63) state_nxt = StAdd;
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + wv_r[i];
        round_nxt = '0;
        oidx_nxt = '0;
        if (final_r) state_nxt = StOut;
        else if (last_pend_r) state_nxt = StPad;
        else state_nxt = StIdle;
      end
      StOut: if (!out_stall) begin
        oidx_nxt = oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          hash_nxt = HashInit;
          total_nxt = '0;
          padding_nxt = 1'b0;
          wrap_nxt = 1'b0;
          final_nxt = 1'b0;
          last_pend_nxt = 1'b0;
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      hash_r <= HashInit;
      wv_r <= '0;
      w_r <= '0;
      total_r <= '0;
      fill_r <= '0;
      round_r <= '0;
      padding_r <= 1'b0;
      wrap_r <= 1'b0;
      final_r <= 1'b0;
      last_pend_r <= 1'b0;
      bitlen_r <= '0;
      oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      hash_r <= hash_nxt;
      wv_r <= wv_nxt;
      w_r <= w_nxt;
      total_r <= total_nxt;
      fill_r <= fill_nxt;
      round_r <= round_nxt;
      padding_r <= padding_nxt;
      wrap_r <= wrap_nxt;
      final_r <= final_nxt;
      last_pend_r <= last_pend_nxt;
      bitlen_r <= bitlen_nxt;
      oidx_r <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) ring_r[fill_r[5:2]] <= put_word;
    else if (state_r == StRnd && round_r >= 7'd15 && round_r != 7'd63)
      ring_r[tn6[3:0]] <= sched_w;
  end

  assign out_valid = (state_r == StOut);
  assign out_digest_word = hash_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);
endmodule
`default_nettype wire

// ===== design/sha_front.sv =====
// Front end of the hash core: takes byte transactions and classifies them for the queue.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_front import sha_pkg::*; (
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_msg_byte,
  input  wire logic       in_last_byte,
  input  wire logic       in_empty_message,
  output logic            q_valid,
  input  wire logic       q_stall,
  output sha_cmd_t        q_cmd
);
  logic drop;
  assign drop = in_empty_message && !in_last_byte;
  assign in_stall = q_stall;
  assign q_valid = in_valid && !drop;
  assign q_cmd = '{data: in_msg_byte, is_last: in_last_byte, is_empty: in_empty_message};
endmodule
`default_nettype wire

// ===== design/sha256_hash_core.sv =====
// SHA-256 hash core: one byte per transaction, eight digest words per message.
// Each byte is packed into the block; each full 64-byte block then takes load, 64 rounds, add.
// The engine takes no byte while it pads, compresses or outputs; a four-entry queue holds bytes while busy.
// After the final byte, digest words appear one per cycle while out_stall is low.
// Reset (rst_n, synchronous) loads the initial hash values and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module sha256_hash_core import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_msg_byte,
  input  wire logic        in_last_byte,
  input  wire logic        in_empty_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  logic     fq_valid, fq_stall, qe_valid, qe_take;
  sha_cmd_t fq_cmd, qe_cmd;

  sha_front u_front (
    .in_valid, .in_stall, .in_msg_byte, .in_last_byte, .in_empty_message,
    .q_valid(fq_valid), .q_stall(fq_stall), .q_cmd(fq_cmd)
  );
  sha_cmd_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_cmd(fq_cmd),
    .rd_valid(qe_valid), .rd_take(qe_take), .rd_cmd(qe_cmd)
  );
  sha_engine u_engine (
    .clk, .rst_n, .cmd_valid(qe_valid), .cmd_take(qe_take), .cmd(qe_cmd),
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );
endmodule
`default_nettype wire

// ===== design/sha_checker.sv =====
// Port checker for the SHA-256 hash core, bound to the top level.
// Depends on sha256_hash_core ports only.
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_digest_word,
  input wire logic [2:0]  out_word_index,
  input wire logic        out_last_word
);
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word mismatch");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=> out_valid &&
      out_word_index == $past(out_word_index) + 3'd1)
    else $error("word index skip");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word))
    else $error("stalled word changed");
endmodule
bind sha256_hash_core sha_checker u_checker (.*);
`default_nettype wire

// ===== tb/sha256_hash_core_tb.sv =====
// Testbench for sha256_hash_core: drives byte transactions, predicts digests with its own
// SHA-256 model held in a small scoreboard class. Depends on sha_pkg and the core RTL.
`timescale 1ns / 1ps
module sha256_hash_core_tb;
  import sha_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  class digest_scoreboard;
    logic [31:0] chain[8];
    logic [31:0] block_words[16];
    logic [60:0] byte_count;
    int unsigned fill;
    digest_item_t pending[$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = HashInit[i];
      byte_count = '0;
      fill = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] v[8];
      logic [31:0] w, t1, t2, x2, x15;
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w = block_words[t];
        end else begin
          x2 = block_words[(t - 2) & 15];
          x15 = block_words[(t - 15) & 15];
          w = (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10)) + block_words[(t - 7) & 15]
              + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + block_words[t & 15];
          block_words[t & 15] = w;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(6'(t)) + w;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void absorb(logic [7:0] b);
      int unsigned sh;
      sh = (3 - (fill % 4)) * 8;
      if (fill % 4 == 0) block_words[fill / 4] = '0;
      block_words[fill / 4] |= 32'(b) << sh;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_input(logic [7:0] b, logic fin, logic empty);
      logic [63:0] bits;
      digest_item_t d;
      if (!empty) begin
        absorb(b);
        byte_count = byte_count + 61'd1;
      end
      if (!fin) return;
      bits = {byte_count, 3'b000};
      if (LengthFieldBits < 64) bits &= ~64'd0 >> (64 - LengthFieldBits);
      absorb(8'h80);
      while (fill != 56) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(bits[63 - 8 * i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.word = chain[i];
        d.index = 3'(i);
        d.last = (i == 7);
        pending.push_back(d);
      end
      restart();
    endfunction

    function void check_result(logic [31:0] word, logic [2:0] index, logic last);
      digest_item_t d;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, word);
        errors++;
        return;
      end
      d = pending.pop_front();
      if (word !== d.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, d.word, word);
        errors++;
      end
      if (index !== d.index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, d.index, index);
        errors++;
      end
      if (last !== d.last) begin
        $display("%0t: last_word expected %0b actual %0b", $time, d.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] in_msg_byte = '0;
  logic in_last_byte = 0;
  logic in_empty_message = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] out_digest_word;
  logic [2:0] out_word_index;
  logic out_last_word;

  digest_scoreboard sb = new();
  int burst_left = 0;
  bit hold_off_req = 0;

  sha256_hash_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_msg_byte(in_msg_byte),
    .in_last_byte(in_last_byte), .in_empty_message(in_empty_message),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_word(out_last_word)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_digest_word, out_word_index, out_last_word);
  end

  // stall pattern: quiet stretches, random stalls, one long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        hold_off_req = 0;
      end
      if ($urandom_range(0, 40) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin, logic empty);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1;
    in_msg_byte <= b;
    in_last_byte <= fin;
    in_empty_message <= empty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b, fin, empty);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit end_empty);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), (i == len - 1) && !end_empty, 0);
    if (end_empty || len == 0) send_byte(8'($urandom), 1, 1);
  endtask

  initial begin
    int sent;
    int len;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // empty message, single extremes, lengths around padding boundaries
    send_byte(8'h00, 1, 1);
    send_byte(8'hff, 1, 0);
    send_byte(8'h00, 1, 0);
    send_byte(8'h61, 0, 1);
    send_byte(8'h61, 0, 0);
    send_byte(8'h62, 0, 0);
    send_byte(8'h63, 1, 0);
    send_byte(8'hff, 0, 0);
    send_byte(8'h55, 1, 1);
    sent = 9;
    send_message(55, 0);
    send_message(56, 0);
    send_message(64, 1);
    sent += 176;

    hold_off_req = 1;
    while (hold_off_req) begin
      send_byte(8'($urandom), $urandom_range(0, 7) == 0, 0);
      sent++;
    end

    while (sent < 420) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = $urandom_range(50, 70);
        default: len = $urandom_range(1, 12);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        send_byte(8'($urandom), 0, 1);
        sent++;
      end
      send_message(len, $urandom_range(0, 4) == 0);
      sent += len + 1;
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
